[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion macros used by k_truss_edge_peeling_unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check, disabled while in reset.
`define KTP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ktp check failed");

// Check that a condition is followed by another one in the next cycle.
`define KTP_ASSERT_NEXT(lbl, clk, rst, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error("ktp sequence check failed");

`endif

[rtl/core/ktp_pkg.sv]
// ----------------------------------------------------------------------------
// ktp_pkg
// Shared types and constants of the k-truss edge peeling unit.
// ----------------------------------------------------------------------------
package ktp_pkg;

  localparam int NODE_W          = 10;
  localparam int SLOT_W          = 13;
  localparam int K_W             = 11;
  localparam int COUNT_W         = 13;
  localparam int COUNT_MAX       = 8191;
  localparam int DEF_MAX_NODES   = 1024;
  localparam int DEF_MAX_ENTRIES = 8192;
  localparam logic [K_W-1:0] K_RESET = 11'd3;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_RUN   = 2'd1,
    FN_QUERY = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ORDER    = 2'd2,
    ST_UNLOADED = 2'd3
  } status_t;

endpackage

[rtl/core/k_truss_edge_peeling_unit.sv]
// Load: fills row_start entries across skipped nodes, then stores the edge.
// Query: reads the slot, then captures it. Clear, rejected load, run with
// nothing to peel: straight to the result. Run: fills unused rows, then each
// sweep checks every slot; a candidate edge reads its row bounds and merges,
// a removal also scans the reverse row; sweeps repeat until one removes nothing.
// Next word taken once each result is issued. Reset: synchronous, empties store.
// ----------------------------------------------------------------------------
// k_truss_edge_peeling_unit
// Adjacency store with an iterative merge-based k-truss peeling sequencer.
// ----------------------------------------------------------------------------
module k_truss_edge_peeling_unit #(
  parameter int MAX_NODES   = ktp_pkg::DEF_MAX_NODES,
  parameter int MAX_ENTRIES = ktp_pkg::DEF_MAX_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ktp_pkg::K_W-1:0]      cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic [ktp_pkg::NODE_W-1:0]   node,
  input  logic [ktp_pkg::NODE_W-1:0]   neighbor,
  input  logic [ktp_pkg::SLOT_W-1:0]   slot,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [ktp_pkg::COUNT_W-1:0]  edge_count,
  output logic [ktp_pkg::NODE_W-1:0]   entry_node,
  output logic [ktp_pkg::NODE_W-1:0]   entry_neighbor,
  output logic                         entry_kept
);
  import ktp_pkg::*;

  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int RW = $clog2(MAX_NODES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_FILL, S_STORE, S_RUN_RD, S_RUN_CHK,
    S_RS_A, S_RS_B, S_RS_C, S_RS_D, S_RS_E,
    S_M_RD, S_M_CMP, S_RM, S_RV_RD, S_RV_CMP, S_NEXT,
    S_Q_RD, S_Q_CAP, S_DONE
  } state_t;

  state_t state;

  logic [K_W-1:0]    truss_k;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     live;
  logic [NODE_W-1:0] last_node;
  logic [NODE_W-1:0] last_nb;
  logic              have_last;

  logic [NODE_W-1:0] r_node;
  logic [NODE_W-1:0] r_nb;
  logic [EW-1:0]     r_slot;
  logic [RW:0]       fill_j;
  logic [RW:0]       fill_end;
  logic              fill_run;

  logic [CW-1:0]     i;
  logic [NODE_W-1:0] u;
  logic [NODE_W-1:0] v;
  logic [CW-1:0]     a;
  logic [CW-1:0]     ae;
  logic [CW-1:0]     b;
  logic [CW-1:0]     be;
  logic [CW-1:0]     vs;
  logic [CW-1:0]     ve;
  logic [CW-1:0]     j;
  logic [K_W-1:0]    hits;
  logic [K_W-1:0]    need;
  logic              changed;

  logic [1:0]        res_status;
  logic [NODE_W-1:0] res_node;
  logic [NODE_W-1:0] res_nb;
  logic              res_kept;

  // memory ports
  logic              ent_we;
  logic [EW-1:0]     ent_waddr;
  logic [EW-1:0]     addr_a;
  logic [EW-1:0]     addr_b;
  logic [NODE_W-1:0] src_rd;
  logic [NODE_W-1:0] nb_rd_a;
  logic [NODE_W-1:0] nb_rd_b;
  logic              rem_we;
  logic [EW-1:0]     rem_waddr;
  logic              rem_wdata;
  logic              rem_rd_a;
  logic              rem_rd_b;
  logic              rs_we;
  logic [RW-1:0]     rs_raddr;
  logic [CW-1:0]     rs_rd;

  assign in_ready  = (state == S_IDLE);
  assign need      = truss_k - K_W'(2);
  assign ent_we    = (state == S_STORE);
  assign ent_waddr = cnt[EW-1:0];
  assign addr_b    = b[EW-1:0];
  assign rs_we     = (state == S_FILL) && (fill_j <= fill_end);

  always_comb begin
    case (state)
      S_M_RD:  addr_a = a[EW-1:0];
      S_RV_RD: addr_a = j[EW-1:0];
      S_Q_RD:  addr_a = r_slot;
      default: addr_a = i[EW-1:0];
    endcase
  end

  always_comb begin
    case (state)
      S_RS_B:  rs_raddr = RW'(u) + RW'(1);
      S_RS_C:  rs_raddr = RW'(v);
      S_RS_D:  rs_raddr = RW'(v) + RW'(1);
      default: rs_raddr = RW'(u);
    endcase
  end

  always_comb begin
    rem_we    = 1'b0;
    rem_waddr = i[EW-1:0];
    rem_wdata = 1'b1;
    case (state)
      S_STORE: begin
        rem_we    = 1'b1;
        rem_waddr = cnt[EW-1:0];
        rem_wdata = 1'b0;
      end
      S_RM: begin
        rem_we = 1'b1;
      end
      S_RV_CMP: begin
        rem_we    = (nb_rd_a == u);
        rem_waddr = j[EW-1:0];
      end
      default: begin
        rem_we = 1'b0;
      end
    endcase
  end

  ktp_ram_1r #(.DEPTH(MAX_ENTRIES), .WIDTH(NODE_W), .AW(EW)) u_src (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(r_node),
    .raddr(addr_a), .rdata(src_rd)
  );

  ktp_ram_2r #(.DEPTH(MAX_ENTRIES), .WIDTH(NODE_W), .AW(EW)) u_nb (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(r_nb),
    .raddr_a(addr_a), .rdata_a(nb_rd_a), .raddr_b(addr_b), .rdata_b(nb_rd_b)
  );

  ktp_ram_2r #(.DEPTH(MAX_ENTRIES), .WIDTH(1), .AW(EW)) u_rem (
    .clk(clk), .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
    .raddr_a(addr_a), .rdata_a(rem_rd_a), .raddr_b(addr_b), .rdata_b(rem_rd_b)
  );

  ktp_ram_1r #(.DEPTH(MAX_NODES + 1), .WIDTH(CW), .AW(RW)) u_rs (
    .clk(clk), .we(rs_we), .waddr(fill_j[RW-1:0]), .wdata(cnt),
    .raddr(rs_raddr), .rdata(rs_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      truss_k   <= K_RESET;
      cnt       <= '0;
      live      <= '0;
      last_node <= '0;
      have_last <= 1'b0;
    end else begin
      if (cfg_we) begin
        truss_k <= cfg_wdata;
      end
      // S_DONE issues the next word itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_node     <= node;
            r_nb       <= neighbor;
            r_slot     <= EW'(slot);
            res_status <= ST_OK;
            res_node   <= '0;
            res_nb     <= '0;
            res_kept   <= 1'b0;
            state      <= S_DONE;
            case (func)
              FN_LOAD: begin
                if (cnt >= CW'(MAX_ENTRIES)) begin
                  res_status <= ST_FULL;
                end else if (node == neighbor || 32'(node) >= 32'(MAX_NODES) ||
                             32'(neighbor) >= 32'(MAX_NODES)) begin
                  res_status <= ST_ORDER;
                end else if (have_last && (node < last_node ||
                             (node == last_node && neighbor <= last_nb))) begin
                  res_status <= ST_ORDER;
                end else begin
                  fill_j   <= (cnt == '0) ? '0 : (RW + 1)'(last_node) + 1'b1;
                  fill_end <= (RW + 1)'(node);
                  fill_run <= 1'b0;
                  state    <= S_FILL;
                end
              end
              FN_RUN: begin
                if (cnt != '0 && truss_k > K_W'(2)) begin
                  fill_j   <= (RW + 1)'(last_node) + 1'b1;
                  fill_end <= (RW + 1)'(MAX_NODES);
                  fill_run <= 1'b1;
                  state    <= S_FILL;
                end
              end
              FN_QUERY: begin
                if (32'(slot) < 32'(cnt)) begin
                  state <= S_Q_RD;
                end else begin
                  res_status <= ST_UNLOADED;
                end
              end
              FN_CLEAR: begin
                cnt       <= '0;
                live      <= '0;
                last_node <= '0;
                have_last <= 1'b0;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_FILL: begin
          if (fill_j <= fill_end) begin
            fill_j <= fill_j + 1'b1;
          end else if (fill_run) begin
            i       <= '0;
            changed <= 1'b0;
            state   <= S_RUN_RD;
          end else begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          cnt       <= cnt + 1'b1;
          last_node <= r_node;
          last_nb   <= r_nb;
          have_last <= 1'b1;
          if (r_node < r_nb) begin
            live <= live + 1'b1;
          end
          state <= S_DONE;
        end
        S_RUN_RD: begin
          state <= S_RUN_CHK;
        end
        S_RUN_CHK: begin
          if (src_rd < nb_rd_a && !rem_rd_a) begin
            u     <= src_rd;
            v     <= nb_rd_a;
            state <= S_RS_A;
          end else begin
            state <= S_NEXT;
          end
        end
        S_RS_A: state <= S_RS_B;
        S_RS_B: begin
          a     <= rs_rd;
          state <= S_RS_C;
        end
        S_RS_C: begin
          ae    <= rs_rd;
          state <= S_RS_D;
        end
        S_RS_D: begin
          b     <= rs_rd;
          vs    <= rs_rd;
          state <= S_RS_E;
        end
        S_RS_E: begin
          be    <= rs_rd;
          ve    <= rs_rd;
          hits  <= '0;
          state <= S_M_RD;
        end
        S_M_RD: begin
          if (a >= ae || b >= be) begin
            state <= (hits >= need) ? S_NEXT : S_RM;
          end else begin
            state <= S_M_CMP;
          end
        end
        S_M_CMP: begin
          state <= S_M_RD;
          if (rem_rd_a || rem_rd_b) begin
            // skip removed entries on either side
            if (rem_rd_a) a <= a + 1'b1;
            if (rem_rd_b) b <= b + 1'b1;
          end else if (nb_rd_a < nb_rd_b) begin
            a <= a + 1'b1;
          end else if (nb_rd_b < nb_rd_a) begin
            b <= b + 1'b1;
          end else begin
            hits <= hits + 1'b1;
            a    <= a + 1'b1;
            b    <= b + 1'b1;
            if ({1'b0, hits} + 1'b1 >= {1'b0, need}) begin
              state <= S_NEXT;
            end
          end
        end
        S_RM: begin
          live  <= live - 1'b1;
          j     <= vs;
          state <= S_RV_RD;
        end
        S_RV_RD: begin
          if (j >= ve) begin
            changed <= 1'b1;
            state   <= S_NEXT;
          end else begin
            state <= S_RV_CMP;
          end
        end
        S_RV_CMP: begin
          j     <= j + 1'b1;
          state <= S_RV_RD;
        end
        S_NEXT: begin
          i     <= i + 1'b1;
          state <= S_RUN_RD;
          if (i + 1'b1 >= cnt) begin
            if (changed) begin
              // start another sweep
              i       <= '0;
              changed <= 1'b0;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_Q_RD: state <= S_Q_CAP;
        S_Q_CAP: begin
          res_node <= src_rd;
          res_nb   <= nb_rd_a;
          res_kept <= ~rem_rd_a;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            edge_count     <= (32'(live) > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                           : COUNT_W'(live);
            entry_node     <= res_node;
            entry_neighbor <= res_nb;
            entry_kept     <= res_kept;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `KTP_ASSERT(a_cnt_bound, clk, rst, cnt <= CW'(MAX_ENTRIES))
  `KTP_ASSERT(a_live_bound, clk, rst, live <= cnt)
  `KTP_ASSERT(a_merge_ptrs, clk, rst, (state != S_M_CMP) || (a < ae && b < be))
  `KTP_ASSERT_NEXT(a_one_word, clk, rst, in_valid && in_ready, !in_ready)

endmodule

[rtl/core/ktp_ram_1r.sv]
// ----------------------------------------------------------------------------
// ktp_ram_1r
// Simple RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ktp_ram_1r #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ktp_ram_2r.sv]
// ----------------------------------------------------------------------------
// ktp_ram_2r
// RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ktp_ram_2r #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
